// File: sv/pcoc_pkg.sv
// Package with shared types and constants of the path crossing opening check.
package pcoc_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_ACT_DIST = 2'd0,
    CFG_LAT_MARGIN = 2'd1,
    CFG_MIN_ALIGN = 2'd2
  } cfg_idx_e;

  // Field widths.
  localparam int unsigned CoordW = 24;
  localparam int unsigned NormW = 16;
  localparam int unsigned SizeW = 23;
  localparam int unsigned AlignW = 16;
  localparam int unsigned CfgW = 23;

  // Shared multiplier: operands, half operands, product, accumulator.
  localparam int unsigned OpW = 45;
  localparam int unsigned HalfW = 22;
  localparam int unsigned ProdW = 88;
  localparam int unsigned AccW = 90;

  // Largest legal alignment value (1.0 in Q1.15).
  localparam logic [AlignW-1:0] AlignOne = 16'd32768;

  // Sequencer states.
  typedef enum logic [5:0] {
    ST_IDLE, ST_EV_CHK,
    ST_V_D0, ST_V_D1, ST_V_D2, ST_V_DC,
    ST_V_L0, ST_V_L1, ST_V_T0, ST_V_T1, ST_V_IC,
    ST_NS_RD, ST_NS_M0, ST_NS_M1, ST_NS_C,
    ST_SG_R0, ST_SG_R1, ST_SG_R2, ST_SG_Z,
    ST_SG_A0, ST_SG_A1, ST_SG_A2, ST_SG_A3, ST_SG_A4, ST_SG_A5, ST_SG_A6, ST_SG_AC,
    ST_SG_F0, ST_SG_F1, ST_SG_S0, ST_SG_S1, ST_SG_FC,
    ST_SG_LF0, ST_SG_LF1, ST_SG_LS0, ST_SG_LS1,
    ST_SG_N0, ST_SG_N1, ST_SG_N2, ST_SG_NC,
    ST_FIN
  } state_e;

endpackage

// File: sv/pcoc_in_if.sv
// Input channel of the path crossing opening check.
interface pcoc_in_if;
  logic valid;
  logic ready;
  logic mode;
  logic signed [23:0] point_x;
  logic signed [23:0] point_y;
  logic signed [23:0] center_x;
  logic signed [23:0] center_y;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic [22:0] opening_width;
  logic [22:0] opening_depth;
  logic last;

  modport source (output valid, mode, point_x, point_y, center_x, center_y, normal_x,
                  normal_y, opening_width, opening_depth, last, input ready);
  modport sink (input valid, mode, point_x, point_y, center_x, center_y, normal_x,
                normal_y, opening_width, opening_depth, last, output ready);
endinterface

// File: sv/pcoc_out_if.sv
// Result channel of the path crossing opening check.
interface pcoc_out_if;
  logic valid;
  logic ready;
  logic crosses;
  logic overflow;

  modport source (output valid, crosses, overflow, input ready);
  modport sink (input valid, crosses, overflow, output ready);
endinterface

// File: sv/path_crosses_opening_check_core.sv
// Top level of the path crossing opening check with its sequencer and shared multiplier.
//
// A query is a start transaction (mode 0) with the vehicle position and the
// opening, followed by guide point transactions (mode 1). The transaction
// with last set ends the query and causes one result transaction: crosses
// and overflow. Guide points are stored one per cycle; points beyond
// MAX_POINTS are dropped and reported as overflow.
// After the last transaction the block is busy while one shared 22x22-bit
// multiplier walks a fixed sequence of products: the vehicle checks, the
// nearest point search over every stored point, and a forward walk over
// the segments from the nearest point. Configuration writes are taken in
// any cycle and should happen while idle. The result sits in an output
// register; the input side is ready again as soon as the result is
// registered, even while the receiver stalls. A new result waits in the
// final state until the output register is free.
// Reset clears the query state, the point count and the output valid flag,
// and loads the configuration reset values.
module path_crosses_opening_check_core #(
  parameter int unsigned MAX_POINTS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [22:0] cfg_data_i,
  pcoc_in_if.sink     in_if,
  pcoc_out_if.source  out_if
);

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  // Configuration registers.
  logic [22:0] act_q, margin_q;
  logic [15:0] align_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 23'd2560;
      margin_q <= '0;
      align_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pcoc_pkg::CFG_ACT_DIST: act_q <= cfg_data_i;
        pcoc_pkg::CFG_LAT_MARGIN: margin_q <= cfg_data_i;
        pcoc_pkg::CFG_MIN_ALIGN: align_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers.
  pcoc_pkg::state_e st_q, st_d;
  logic signed [23:0] vx_q, vy_q, cx_q, cy_q;
  logic signed [15:0] nx_q, ny_q;
  logic [22:0] sw_q, sd_q;
  logic [CW-1:0] cnt_q;
  logic drop_q;
  logic [CW-1:0] idx_q, idx_d, near_q, near_d;
  logic [51:0] best_q, best_d;
  logic res_q, res_d;
  logic signed [23:0] x0_q, y0_q, x1_q, y1_q;
  logic signed [44:0] t1_q, t2_q, dot_q, f_q, s_q, lf_q, ls_q;
  logic signed [89:0] acc_q, acc_d;
  logic [1:0] mcnt_q;
  logic [87:0] pacc_q;
  logic out_valid_q, out_valid_d, crosses_q, overflow_q;

  // Guide point store.
  logic signed [23:0] gx_mem [MAX_POINTS];
  logic signed [23:0] gy_mem [MAX_POINTS];
  logic signed [23:0] rdx_q, rdy_q;
  logic rd_en;
  logic [AW-1:0] rd_addr;

  logic in_acc, wr_en;
  assign in_if.ready = (st_q == pcoc_pkg::ST_IDLE);
  assign in_acc = in_if.valid && in_if.ready;
  assign wr_en = in_acc && in_if.mode && (cnt_q < CW'(MAX_POINTS));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      gx_mem[cnt_q[AW-1:0]] <= in_if.point_x;
      gy_mem[cnt_q[AW-1:0]] <= in_if.point_y;
    end
    if (rd_en) begin
      rdx_q <= gx_mem[rd_addr];
      rdy_q <= gy_mem[rd_addr];
    end
  end

  // Query state loaded by start and guide transactions.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vx_q <= '0; vy_q <= '0; cx_q <= '0; cy_q <= '0;
      nx_q <= '0; ny_q <= '0; sw_q <= '0; sd_q <= '0;
      cnt_q <= '0;
      drop_q <= 1'b0;
    end else if (in_acc) begin
      if (!in_if.mode) begin
        vx_q <= in_if.point_x; vy_q <= in_if.point_y;
        cx_q <= in_if.center_x; cy_q <= in_if.center_y;
        nx_q <= in_if.normal_x; ny_q <= in_if.normal_y;
        sw_q <= in_if.opening_width; sd_q <= in_if.opening_depth;
        cnt_q <= '0;
        drop_q <= 1'b0;
      end else if (wr_en) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        drop_q <= 1'b1;
      end
    end
  end

  // Differences feeding the multiplier.
  logic signed [24:0] dvx, dvy, ex, ey, sx, sy, d0x, d0y, d1x, d1y;
  logic signed [44:0] fms, fms_abs;
  logic [23:0] wd;
  logic [36:0] w2;
  assign dvx = 25'(vx_q) - 25'(cx_q);
  assign dvy = 25'(vy_q) - 25'(cy_q);
  assign ex = 25'(rdx_q) - 25'(vx_q);
  assign ey = 25'(rdy_q) - 25'(vy_q);
  assign sx = 25'(x1_q) - 25'(x0_q);
  assign sy = 25'(y1_q) - 25'(y0_q);
  assign d0x = 25'(x0_q) - 25'(cx_q);
  assign d0y = 25'(y0_q) - 25'(cy_q);
  assign d1x = 25'(x1_q) - 25'(cx_q);
  assign d1y = 25'(y1_q) - 25'(cy_q);
  assign fms = f_q - s_q;
  assign fms_abs = fms[44] ? -fms : fms;
  assign wd = {1'b0, sw_q} - {margin_q, 1'b0};
  assign w2 = {wd[22:0], 14'd0};

  // Operand selection of the shared multiplier.
  logic signed [44:0] a_s, b_s;
  logic clr_s, sub_s, absb_s, is_mul;
  always_comb begin
    a_s = '0; b_s = '0; clr_s = 1'b0; sub_s = 1'b0; absb_s = 1'b0; is_mul = 1'b1;
    case (st_q)
      pcoc_pkg::ST_V_D0: begin a_s = 45'(dvx); b_s = 45'(dvx); clr_s = 1'b1; end
      pcoc_pkg::ST_V_D1: begin a_s = 45'(dvy); b_s = 45'(dvy); end
      pcoc_pkg::ST_V_D2: begin
        a_s = 45'({1'b0, act_q}); b_s = 45'({1'b0, act_q}); sub_s = 1'b1;
      end
      pcoc_pkg::ST_V_L0: begin a_s = 45'(dvx); b_s = 45'(nx_q); clr_s = 1'b1; end
      pcoc_pkg::ST_V_L1: begin a_s = 45'(dvy); b_s = 45'(ny_q); end
      pcoc_pkg::ST_V_T0: begin a_s = 45'(dvy); b_s = 45'(nx_q); clr_s = 1'b1; end
      pcoc_pkg::ST_V_T1: begin a_s = 45'(dvx); b_s = 45'(ny_q); sub_s = 1'b1; end
      pcoc_pkg::ST_NS_M0: begin a_s = 45'(ex); b_s = 45'(ex); clr_s = 1'b1; end
      pcoc_pkg::ST_NS_M1: begin a_s = 45'(ey); b_s = 45'(ey); end
      pcoc_pkg::ST_SG_A0: begin
        a_s = 45'({1'b0, align_q}); b_s = 45'(sx); clr_s = 1'b1;
      end
      pcoc_pkg::ST_SG_A1: begin
        a_s = 45'({1'b0, align_q}); b_s = 45'(sy); clr_s = 1'b1;
      end
      pcoc_pkg::ST_SG_A2: begin a_s = 45'(sx); b_s = 45'(nx_q); clr_s = 1'b1; end
      pcoc_pkg::ST_SG_A3: begin a_s = 45'(sy); b_s = 45'(ny_q); end
      pcoc_pkg::ST_SG_A4: begin a_s = dot_q <<< 1; b_s = dot_q <<< 1; clr_s = 1'b1; end
      pcoc_pkg::ST_SG_A5: begin a_s = t1_q; b_s = t1_q; sub_s = 1'b1; end
      pcoc_pkg::ST_SG_A6: begin a_s = t2_q; b_s = t2_q; sub_s = 1'b1; end
      pcoc_pkg::ST_SG_F0: begin a_s = 45'(d0x); b_s = 45'(nx_q); clr_s = 1'b1; end
      pcoc_pkg::ST_SG_F1: begin a_s = 45'(d0y); b_s = 45'(ny_q); end
      pcoc_pkg::ST_SG_S0: begin a_s = 45'(d1x); b_s = 45'(nx_q); clr_s = 1'b1; end
      pcoc_pkg::ST_SG_S1: begin a_s = 45'(d1y); b_s = 45'(ny_q); end
      pcoc_pkg::ST_SG_LF0: begin a_s = 45'(d0y); b_s = 45'(nx_q); clr_s = 1'b1; end
      pcoc_pkg::ST_SG_LF1: begin a_s = 45'(d0x); b_s = 45'(ny_q); sub_s = 1'b1; end
      pcoc_pkg::ST_SG_LS0: begin a_s = 45'(d1y); b_s = 45'(nx_q); clr_s = 1'b1; end
      pcoc_pkg::ST_SG_LS1: begin a_s = 45'(d1x); b_s = 45'(ny_q); sub_s = 1'b1; end
      pcoc_pkg::ST_SG_N0: begin a_s = f_q <<< 1; b_s = ls_q; clr_s = 1'b1; end
      pcoc_pkg::ST_SG_N1: begin a_s = s_q <<< 1; b_s = lf_q; sub_s = 1'b1; end
      pcoc_pkg::ST_SG_N2: begin
        a_s = 45'({1'b0, w2}); b_s = fms_abs; sub_s = 1'b1; absb_s = 1'b1;
      end
      default: is_mul = 1'b0;
    endcase
  end

  // Shared multiplier: one 22x22 partial product per cycle, four per product.
  logic [43:0] ma, mb, pp;
  logic [21:0] pa, pb;
  logic [87:0] pp_sh, psum;
  logic signed [89:0] prod_s, base_s;
  logic mul_done;
  assign ma = a_s[44] ? 44'(-a_s) : a_s[43:0];
  assign mb = b_s[44] ? 44'(-b_s) : b_s[43:0];
  assign pa = mcnt_q[0] ? ma[43:22] : ma[21:0];
  assign pb = mcnt_q[1] ? mb[43:22] : mb[21:0];
  assign pp = 44'(pa) * 44'(pb);
  always_comb begin
    case (mcnt_q)
      2'd0: pp_sh = 88'(pp);
      2'd3: pp_sh = 88'(pp) << (2 * pcoc_pkg::HalfW);
      default: pp_sh = 88'(pp) << pcoc_pkg::HalfW;
    endcase
  end
  assign psum = ((mcnt_q == 2'd0) ? 88'd0 : pacc_q) + pp_sh;
  assign prod_s = (a_s[44] ^ b_s[44] ^ sub_s) ? -$signed({2'b00, psum})
                                                : $signed({2'b00, psum});
  assign base_s = clr_s ? 90'sd0 : ((absb_s && acc_q < 0) ? -acc_q : acc_q);
  assign acc_d = base_s + prod_s;
  assign mul_done = is_mul && (mcnt_q == 2'd3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcnt_q <= '0;
    end else if (is_mul) begin
      mcnt_q <= mcnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_mul) pacc_q <= psum;
    if (mul_done) acc_q <= acc_d;
    if (mul_done) begin
      case (st_q)
        pcoc_pkg::ST_V_L1: f_q <= acc_d[44:0];
        pcoc_pkg::ST_SG_A0: t1_q <= acc_d[44:0];
        pcoc_pkg::ST_SG_A1: t2_q <= acc_d[44:0];
        pcoc_pkg::ST_SG_A3: dot_q <= acc_d[44:0];
        pcoc_pkg::ST_SG_F1: f_q <= acc_d[44:0];
        pcoc_pkg::ST_SG_S1: s_q <= acc_d[44:0];
        pcoc_pkg::ST_SG_LF1: lf_q <= acc_d[44:0];
        pcoc_pkg::ST_SG_LS1: ls_q <= acc_d[44:0];
        default: ;
      endcase
    end
    if (st_q == pcoc_pkg::ST_SG_R1) begin
      x0_q <= rdx_q; y0_q <= rdy_q;
    end
    if (st_q == pcoc_pkg::ST_SG_R2) begin
      x1_q <= rdx_q; y1_q <= rdy_q;
    end
    best_q <= best_d;
  end

  // Vehicle inside check operands.
  logic [43:0] lv_m, lt_m;
  logic signed [44:0] lt_s;
  logic [CW:0] idx_p1;
  assign lt_s = acc_q[44:0];
  assign lv_m = f_q[44] ? 44'(-f_q) : f_q[43:0];
  assign lt_m = lt_s[44] ? 44'(-lt_s) : lt_s[43:0];
  assign idx_p1 = {1'b0, idx_q} + 1'b1;

  // Next state and sequencer outputs.
  always_comb begin
    st_d = st_q;
    idx_d = idx_q;
    near_d = near_q;
    best_d = best_q;
    res_d = res_q;
    rd_en = 1'b0;
    rd_addr = idx_q[AW-1:0];
    out_valid_d = out_valid_q && !out_if.ready;
    case (st_q)
      pcoc_pkg::ST_IDLE: begin
        if (in_acc && in_if.last) st_d = pcoc_pkg::ST_EV_CHK;
      end
      pcoc_pkg::ST_EV_CHK: begin
        res_d = 1'b0;
        if (cnt_q < CW'(2) || act_q == '0 || align_q > pcoc_pkg::AlignOne ||
            {1'b0, sw_q} <= {margin_q, 1'b0}) begin
          st_d = pcoc_pkg::ST_FIN;
        end else begin
          st_d = pcoc_pkg::ST_V_D0;
        end
      end
      pcoc_pkg::ST_V_DC: begin
        st_d = (acc_q > 0) ? pcoc_pkg::ST_FIN : pcoc_pkg::ST_V_L0;
      end
      pcoc_pkg::ST_V_IC: begin
        idx_d = '0;
        if ({lv_m, 1'b0} <= 45'({sd_q, 14'd0}) && {lt_m, 1'b0} <= 45'(w2)) begin
          res_d = 1'b1;
          st_d = pcoc_pkg::ST_FIN;
        end else begin
          st_d = pcoc_pkg::ST_NS_RD;
        end
      end
      pcoc_pkg::ST_NS_RD: begin
        rd_en = 1'b1;
        st_d = pcoc_pkg::ST_NS_M0;
      end
      pcoc_pkg::ST_NS_C: begin
        if (idx_q == '0 || acc_q[51:0] < best_q) begin
          best_d = acc_q[51:0];
          near_d = idx_q;
        end
        if (idx_p1 == {1'b0, cnt_q}) begin
          idx_d = near_d;
          st_d = pcoc_pkg::ST_SG_R0;
        end else begin
          idx_d = idx_p1[CW-1:0];
          st_d = pcoc_pkg::ST_NS_RD;
        end
      end
      pcoc_pkg::ST_SG_R0: begin
        if (idx_p1 >= {1'b0, cnt_q}) begin
          res_d = 1'b0;
          st_d = pcoc_pkg::ST_FIN;
        end else begin
          rd_en = 1'b1;
          st_d = pcoc_pkg::ST_SG_R1;
        end
      end
      pcoc_pkg::ST_SG_R1: begin
        rd_en = 1'b1;
        rd_addr = idx_p1[AW-1:0];
        st_d = pcoc_pkg::ST_SG_R2;
      end
      pcoc_pkg::ST_SG_R2: st_d = pcoc_pkg::ST_SG_Z;
      pcoc_pkg::ST_SG_Z: begin
        if (sx == '0 && sy == '0) begin
          idx_d = idx_p1[CW-1:0];
          st_d = pcoc_pkg::ST_SG_R0;
        end else begin
          st_d = pcoc_pkg::ST_SG_A0;
        end
      end
      pcoc_pkg::ST_SG_AC: begin
        if (acc_q < 0) begin
          idx_d = idx_p1[CW-1:0];
          st_d = pcoc_pkg::ST_SG_R0;
        end else begin
          st_d = pcoc_pkg::ST_SG_F0;
        end
      end
      pcoc_pkg::ST_SG_FC: begin
        if ((f_q > 0 && s_q > 0) || (f_q < 0 && s_q < 0) || f_q == s_q) begin
          idx_d = idx_p1[CW-1:0];
          st_d = pcoc_pkg::ST_SG_R0;
        end else begin
          st_d = pcoc_pkg::ST_SG_LF0;
        end
      end
      pcoc_pkg::ST_SG_NC: begin
        if (acc_q <= 0) begin
          res_d = 1'b1;
          st_d = pcoc_pkg::ST_FIN;
        end else begin
          idx_d = idx_p1[CW-1:0];
          st_d = pcoc_pkg::ST_SG_R0;
        end
      end
      pcoc_pkg::ST_FIN: begin
        if (!out_valid_q || out_if.ready) begin
          out_valid_d = 1'b1;
          st_d = pcoc_pkg::ST_IDLE;
        end
      end
      default: begin
        // Product states advance in program order once the product is done.
        if (mul_done) begin
          case (st_q)
            pcoc_pkg::ST_V_D0: st_d = pcoc_pkg::ST_V_D1;
            pcoc_pkg::ST_V_D1: st_d = pcoc_pkg::ST_V_D2;
            pcoc_pkg::ST_V_D2: st_d = pcoc_pkg::ST_V_DC;
            pcoc_pkg::ST_V_L0: st_d = pcoc_pkg::ST_V_L1;
            pcoc_pkg::ST_V_L1: st_d = pcoc_pkg::ST_V_T0;
            pcoc_pkg::ST_V_T0: st_d = pcoc_pkg::ST_V_T1;
            pcoc_pkg::ST_V_T1: st_d = pcoc_pkg::ST_V_IC;
            pcoc_pkg::ST_NS_M0: st_d = pcoc_pkg::ST_NS_M1;
            pcoc_pkg::ST_NS_M1: st_d = pcoc_pkg::ST_NS_C;
            pcoc_pkg::ST_SG_A0: st_d = pcoc_pkg::ST_SG_A1;
            pcoc_pkg::ST_SG_A1: st_d = pcoc_pkg::ST_SG_A2;
            pcoc_pkg::ST_SG_A2: st_d = pcoc_pkg::ST_SG_A3;
            pcoc_pkg::ST_SG_A3: st_d = pcoc_pkg::ST_SG_A4;
            pcoc_pkg::ST_SG_A4: st_d = pcoc_pkg::ST_SG_A5;
            pcoc_pkg::ST_SG_A5: st_d = pcoc_pkg::ST_SG_A6;
            pcoc_pkg::ST_SG_A6: st_d = pcoc_pkg::ST_SG_AC;
            pcoc_pkg::ST_SG_F0: st_d = pcoc_pkg::ST_SG_F1;
            pcoc_pkg::ST_SG_F1: st_d = pcoc_pkg::ST_SG_S0;
            pcoc_pkg::ST_SG_S0: st_d = pcoc_pkg::ST_SG_S1;
            pcoc_pkg::ST_SG_S1: st_d = pcoc_pkg::ST_SG_FC;
            pcoc_pkg::ST_SG_LF0: st_d = pcoc_pkg::ST_SG_LF1;
            pcoc_pkg::ST_SG_LF1: st_d = pcoc_pkg::ST_SG_LS0;
            pcoc_pkg::ST_SG_LS0: st_d = pcoc_pkg::ST_SG_LS1;
            pcoc_pkg::ST_SG_LS1: st_d = pcoc_pkg::ST_SG_N0;
            pcoc_pkg::ST_SG_N0: st_d = pcoc_pkg::ST_SG_N1;
            pcoc_pkg::ST_SG_N1: st_d = pcoc_pkg::ST_SG_N2;
            pcoc_pkg::ST_SG_N2: st_d = pcoc_pkg::ST_SG_NC;
            default: st_d = pcoc_pkg::ST_IDLE;
          endcase
        end
      end
    endcase
  end

  // State, indexes and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= pcoc_pkg::ST_IDLE;
      idx_q <= '0;
      near_q <= '0;
      res_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      idx_q <= idx_d;
      near_q <= near_d;
      res_q <= res_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == pcoc_pkg::ST_FIN && (!out_valid_q || out_if.ready)) begin
      crosses_q <= res_q;
      overflow_q <= drop_q;
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.crosses = crosses_q;
  assign out_if.overflow = overflow_q;

  // The multiplier step counter is at rest whenever the sequencer is idle.
  a_idle_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == pcoc_pkg::ST_IDLE |-> mcnt_q == 2'd0)
    else $error("multiplier step counter busy while idle");

  // The point count never passes the store capacity.
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_POINTS))
    else $error("point count beyond capacity");

  // A segment read always has a following point in the store.
  a_seg_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == pcoc_pkg::ST_SG_R1 |-> idx_p1 < {1'b0, cnt_q})
    else $error("segment walk past the last point");

  // A result appears only when leaving the final state.
  a_res_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(st_q == pcoc_pkg::ST_FIN))
    else $error("result without evaluation");

endmodule
